### design/bitmap_page_allocator_top_assert.svh
// Assertion macros for the bitmap page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BPA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPA_ASSERT_SAME(label, ante, cons, msg)
`define BPA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### design/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int MAX_PAGES = 65536;
  localparam int PAGE_W    = 16;
  localparam int CNT_W     = 17;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int LIMIT_MAX = (MAX_PAGES < (1 << PAGE_W)) ? MAX_PAGES : (1 << PAGE_W);
  localparam int MAP_WORDS = (LIMIT_MAX + WORD_W - 1) / WORD_W;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_MARK  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [BIT_W-1:0]  lo;
    logic              hi_en;
    logic [BIT_W-1:0]  hi;
  } scan_req_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] idx;
  } scan_res_t;

  typedef struct packed {
    logic             clearing;
    logic [CNT_W-1:0] limit;
  } stat_t;

endpackage

### design/bpa_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/bpa_scan.sv
// Find-first-free unit over one bitmap word, bounded below and, when hi_en is set, above.
`timescale 1ns / 1ps
module bpa_scan import bpa_pkg::*; (
  input  scan_req_t req,
  output scan_res_t res
);

  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] avail;
  logic [WORD_W-1:0] lowest;
  logic [BIT_W-1:0]  idx;

  always_comb begin
    hi_mask = req.hi_en ? ((WORD_W'(1) << req.hi) - WORD_W'(1)) : '1;
    avail   = ~req.word & ({WORD_W{1'b1}} << req.lo) & hi_mask;
    // isolate the lowest free bit, then encode it
    lowest  = avail & (~avail + WORD_W'(1));
    idx     = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lowest[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    res.hit = |avail;
    res.idx = idx;
  end

endmodule

### design/bpa_seq.sv
// Sequencer: clearing pass, word-by-word scan, map update and result register.
`timescale 1ns / 1ps
module bpa_seq import bpa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  logic [PAGE_W-1:0]   page,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                found,
  output logic [PAGE_W-1:0]   page_out,
  output logic                range_error,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_data,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [WORD_W-1:0]   ram_wdata,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  input  logic [WORD_W-1:0]   ram_rdata,
  output scan_req_t           scan_req,
  input  scan_res_t           scan_res,
  output stat_t               stat
);

  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT_MAX);

  state_t              state, state_next;
  logic [1:0]          cmd_r, cmd_r_next;
  logic [PAGE_W-1:0]   page_r, page_r_next;
  logic [AW-1:0]       cur_word, cur_word_next;
  logic [BIT_W-1:0]    lo, lo_next;
  logic [PAGE_W-1:0]   hint, hint_next;
  logic [CNT_W-1:0]    page_count;
  logic [AW-1:0]       clr_addr, clr_addr_next;
  logic                res_found, res_found_next;
  logic [PAGE_W-1:0]   res_page, res_page_next;
  logic                res_err, res_err_next;
  logic                out_load;
  logic [CNT_W-1:0]    limit;
  logic [AW:0]         nxt_word;
  logic [CNT_W:0]      nxt_base;

  assign limit    = (page_count > LIMIT_C) ? LIMIT_C : page_count;
  assign nxt_word = {1'b0, cur_word} + (AW+1)'(1);
  assign nxt_base = (CNT_W+1)'(nxt_word) << BIT_W;
  assign in_ready = (state == ST_IDLE);

  assign stat.clearing = (state == ST_CLEAR);
  assign stat.limit    = limit;

  assign scan_req.word  = ram_rdata;
  assign scan_req.lo    = lo;
  assign scan_req.hi_en = ((CNT_W-BIT_W)'(cur_word) == limit[CNT_W-1:BIT_W]);
  assign scan_req.hi    = limit[BIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      hint       <= '0;
      page_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      hint     <= hint_next;
      if (cfg_we) begin
        page_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_r_next;
    page_r    <= page_r_next;
    cur_word  <= cur_word_next;
    lo        <= lo_next;
    res_found <= res_found_next;
    res_page  <= res_page_next;
    res_err   <= res_err_next;
    if (out_load) begin
      found       <= res_found;
      page_out    <= res_page;
      range_error <= res_err;
    end
  end

  always_comb begin
    state_next     = state;
    cmd_r_next     = cmd_r;
    page_r_next    = page_r;
    cur_word_next  = cur_word;
    lo_next        = lo;
    hint_next      = hint;
    clr_addr_next  = clr_addr;
    res_found_next = res_found;
    res_page_next  = res_page;
    res_err_next   = res_err;
    ram_we         = 1'b0;
    ram_waddr      = cur_word;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    out_load       = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '1;
        if (clr_addr == AW'(MAP_WORDS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_r_next     = command;
          page_r_next    = page;
          res_found_next = 1'b0;
          res_page_next  = '0;
          res_err_next   = 1'b0;
          state_next     = ST_DONE;
          case (command)
            CMD_ALLOC: begin
              if (CNT_W'(hint) < limit) begin
                ram_re        = 1'b1;
                ram_raddr     = AW'(hint >> BIT_W);
                cur_word_next = AW'(hint >> BIT_W);
                lo_next       = hint[BIT_W-1:0];
                state_next    = ST_EVAL;
              end
            end
            CMD_FREE, CMD_MARK: begin
              if (CNT_W'(page) >= limit) begin
                res_err_next = 1'b1;
              end else begin
                ram_re        = 1'b1;
                ram_raddr     = AW'(page >> BIT_W);
                cur_word_next = AW'(page >> BIT_W);
                state_next    = ST_EVAL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        if (cmd_r == CMD_ALLOC) begin
          if (scan_res.hit) begin
            ram_we         = 1'b1;
            ram_wdata      = ram_rdata | (WORD_W'(1) << scan_res.idx);
            hint_next      = PAGE_W'({cur_word, scan_res.idx});
            res_found_next = 1'b1;
            res_page_next  = PAGE_W'({cur_word, scan_res.idx});
            state_next     = ST_DONE;
          end else if (nxt_base >= (CNT_W+1)'(limit)) begin
            state_next = ST_DONE;
          end else begin
            // advance to the next word, read issued now
            ram_re        = 1'b1;
            ram_raddr     = nxt_word[AW-1:0];
            cur_word_next = nxt_word[AW-1:0];
            lo_next       = '0;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(WORD_W'(1) << page_r[BIT_W-1:0]);
          if (cmd_r == CMD_FREE && page_r < hint) begin
            hint_next = page_r;
          end
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### design/bitmap_page_allocator_top.sv
// Top level of the bitmap page allocator.
// Next-fit page allocator over a one-bit-per-page map held in a 2048 x 32 RAM.
// After reset a clearing pass writes every map word, setting every page to used;
// requests are held off until it ends, while page_count writes are taken at once.
// An in-range free or mark_free request reads its map word and clears the page's
// bit before its result is registered; an out-of-range free or mark_free, command
// three and an alloc whose hint sits at or above the limit go straight to the
// result register. Any other alloc request scans the map words from the hint, N
// of them (1 to 2048), as the single RAM read port delivers one word per cycle to
// the find-first-free unit. A new request is taken while a finished result still
// waits on the output.
`timescale 1ns / 1ps
`include "bitmap_page_allocator_top_assert.svh"
module bitmap_page_allocator_top import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [PAGE_W-1:0] page,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              found,
  output logic [PAGE_W-1:0] page_out,
  output logic              range_error,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data
);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  scan_req_t         scan_req;
  scan_res_t         scan_res;
  stat_t             stat;

  bpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_scan u_scan (
    .req (scan_req),
    .res (scan_res)
  );

  bpa_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .page        (page),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .page_out    (page_out),
    .range_error (range_error),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .scan_req    (scan_req),
    .scan_res    (scan_res),
    .stat        (stat)
  );

  `BPA_ASSERT_SAME(a_no_req_in_clear, stat.clearing, !in_ready, "request taken during clear")
  `BPA_ASSERT_SAME(a_found_xor_err, out_valid, !(found && range_error), "found with range error")
  `BPA_ASSERT_SAME(a_zero_page, out_valid && !found, page_out == '0, "page without found")
  `BPA_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken twice")
  `BPA_ASSERT_SAME(a_lim, out_valid && found, CNT_W'(page_out) < stat.limit, "page over limit")

endmodule
